// ===== rtl/tpl_pkg.sv =====
// ----------------------------------------------------------------------------
// tpl_pkg: shared types and constants for the task pool
// Word formats of both channels, action codes and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package tpl_pkg;

  localparam int IDX_W = 7;   // width of any entry index or link
  localparam int HND_W = 16;  // width of the handler field on the ports
  localparam int ACT_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_AFTER  = 2'd0,
    ACT_INS_BEFORE = 2'd1,
    ACT_REMOVE     = 2'd2,
    ACT_READ       = 2'd3
  } action_e;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IDX_W-1:0] anchor;
    logic [HND_W-1:0] handler;
  } in_word_t;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] prev_index;
    logic [IDX_W-1:0] next_index;
    logic [HND_W-1:0] entry_handler;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // capture request, issue table reads
    logic wr1;       // first write phase
    logic wr2;       // second write phase (inserts only)
    logic load_out;  // move result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic two_step;  // request needs the second write phase
  } status_t;

endpackage

// ===== rtl/tpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpl_ctrl: request sequencer for the task pool
// Walks each request through capture, one or two write phases and the
// hand-off to the output register; owns both handshakes.
// ----------------------------------------------------------------------------
module tpl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tpl_pkg::status_t  sts_i,
  output tpl_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WR1  = 4'b0010,
    ST_WR2  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_WR1;
        end
      end
      ST_WR1: begin
        cmd_o.wr1 = 1'b1;
        if (sts_i.two_step) begin
          state_d = ST_WR2;
        end else if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_WR2: begin
        cmd_o.wr2 = 1'b1;
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/tpl_dp.sv =====
// ----------------------------------------------------------------------------
// tpl_dp: link tables, handler table, free-index ring and result register
// Each table has one write and one registered read port; link and ring
// tables carry per-entry valid bits so unwritten entries read as reset.
// ----------------------------------------------------------------------------
module tpl_dp #(
  parameter int POOL_ENTRIES = 72,
  parameter int FREE_SLOTS   = 70,
  parameter int HANDLER_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpl_pkg::cmd_t      cmd_i,
  input  tpl_pkg::in_word_t  in_word_i,
  output tpl_pkg::status_t   sts_o,
  output tpl_pkg::out_word_t out_word_o
);

  localparam int IW = tpl_pkg::IDX_W;
  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int SW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int HW = (HANDLER_BITS < tpl_pkg::HND_W) ? HANDLER_BITS : tpl_pkg::HND_W;
  localparam logic [IW:0]   POOL_LIM  = (IW+1)'(POOL_ENTRIES);
  localparam logic [IW-1:0] FREE_LIM  = IW'(FREE_SLOTS);
  localparam logic [SW-1:0] SLOT_LAST = SW'(FREE_SLOTS - 1);

  // out-of-range link values are treated as entry 0
  function automatic logic [IW-1:0] fix_idx(input logic [IW-1:0] v);
    return ({1'b0, v} < POOL_LIM) ? v : '0;
  endfunction

  // ---- storage ----
  logic [IW-1:0] prev_mem [POOL_ENTRIES];
  logic [IW-1:0] next_mem [POOL_ENTRIES];
  logic [HW-1:0] hnd_mem  [POOL_ENTRIES];
  logic [IW-1:0] ring_mem [FREE_SLOTS];
  logic [POOL_ENTRIES-1:0] prev_vld_q, next_vld_q;
  logic [FREE_SLOTS-1:0]   ring_vld_q;

  logic [IW-1:0] used_q, used_d;
  logic [SW-1:0] pop_q, pop_d, push_q, push_d;

  // ---- captured request and read data ----
  tpl_pkg::in_word_t req_q;
  logic              exh_q, bad_q;
  logic [AW-1:0]     rd_addr_q;
  logic [SW-1:0]     slot_q;
  logic [IW-1:0]     prev_rd_q, next_rd_q, ring_rd_q;
  logic              prev_rv_q, next_rv_q, ring_rv_q;
  logic [HW-1:0]     hnd_rd_q;

  logic [AW-1:0] rd_addr;
  logic          in_bad;
  assign in_bad  = !({1'b0, in_word_i.anchor} < POOL_LIM);
  assign rd_addr = in_bad ? '0 : in_word_i.anchor[AW-1:0];

  // ---- decoded values of the current request ----
  logic [IW-1:0] anc, prv, nxt, rng, new_idx, prv_fix, nxt_fix;
  logic [AW-1:0] anc_addr, new_addr, prv_addr, nxt_addr;
  logic          is_ins, do_writes;

  assign anc      = req_q.anchor;
  assign anc_addr = rd_addr_q;
  assign prv      = prev_rv_q ? prev_rd_q : '0;
  assign nxt      = next_rv_q ? next_rd_q : ((rd_addr_q == '0) ? IW'(1) : '0);
  assign rng      = ring_rv_q ? ring_rd_q : (IW'(slot_q) + IW'(2));
  assign new_idx  = fix_idx(rng);
  assign prv_fix  = fix_idx(prv);
  assign nxt_fix  = fix_idx(nxt);
  assign new_addr = new_idx[AW-1:0];
  assign prv_addr = prv_fix[AW-1:0];
  assign nxt_addr = nxt_fix[AW-1:0];

  assign is_ins    = (req_q.action == tpl_pkg::ACT_INS_AFTER) ||
                     (req_q.action == tpl_pkg::ACT_INS_BEFORE);
  assign do_writes = !bad_q && (is_ins ? !exh_q : (req_q.action == tpl_pkg::ACT_REMOVE));
  assign sts_o.two_step = do_writes && is_ins;

  // ---- write port selection ----
  logic          prev_we, next_we, hnd_we, ring_we;
  logic [AW-1:0] prev_wa, next_wa;
  logic [IW-1:0] prev_wd, next_wd;

  always_comb begin
    prev_we = 1'b0;
    prev_wa = '0;
    prev_wd = '0;
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    hnd_we  = 1'b0;
    ring_we = 1'b0;
    if (cmd_i.wr1 && do_writes) begin
      case (req_q.action)
        tpl_pkg::ACT_INS_AFTER: begin
          prev_we = 1'b1; prev_wa = new_addr; prev_wd = anc;
          next_we = 1'b1; next_wa = new_addr; next_wd = nxt;
          hnd_we  = 1'b1;
        end
        tpl_pkg::ACT_INS_BEFORE: begin
          prev_we = 1'b1; prev_wa = new_addr; prev_wd = prv;
          next_we = 1'b1; next_wa = new_addr; next_wd = anc;
          hnd_we  = 1'b1;
        end
        tpl_pkg::ACT_REMOVE: begin
          next_we = 1'b1; next_wa = prv_addr; next_wd = nxt;
          prev_we = 1'b1; prev_wa = nxt_addr; prev_wd = prv;
          ring_we = 1'b1;
        end
        default: ;
      endcase
    end else if (cmd_i.wr2 && do_writes) begin
      case (req_q.action)
        tpl_pkg::ACT_INS_AFTER: begin
          prev_we = 1'b1; prev_wa = nxt_addr; prev_wd = new_idx;
          next_we = 1'b1; next_wa = anc_addr; next_wd = new_idx;
        end
        tpl_pkg::ACT_INS_BEFORE: begin
          next_we = 1'b1; next_wa = prv_addr; next_wd = new_idx;
          prev_we = 1'b1; prev_wa = anc_addr; prev_wd = new_idx;
        end
        default: ;
      endcase
    end
  end

  // ---- pointers and fill count ----
  always_comb begin
    used_d = used_q;
    pop_d  = pop_q;
    push_d = push_q;
    if (cmd_i.wr1 && do_writes) begin
      if (is_ins) begin
        used_d = used_q + IW'(1);
        pop_d  = (pop_q == SLOT_LAST) ? '0 : pop_q + SW'(1);
      end else begin
        used_d = used_q - IW'(1);
        push_d = (push_q == SLOT_LAST) ? '0 : push_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      pop_q      <= '0;
      push_q     <= '0;
      prev_vld_q <= '0;
      next_vld_q <= '0;
      ring_vld_q <= '0;
    end else begin
      used_q <= used_d;
      pop_q  <= pop_d;
      push_q <= push_d;
      if (prev_we) prev_vld_q[prev_wa] <= 1'b1;
      if (next_we) next_vld_q[next_wa] <= 1'b1;
      if (ring_we) ring_vld_q[push_q]  <= 1'b1;
    end
  end

  // ---- tables: one write, one registered read each ----
  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (hnd_we)  hnd_mem[new_addr] <= req_q.handler[HW-1:0];
    if (ring_we) ring_mem[push_q]  <= anc;
    if (cmd_i.accept) begin
      prev_rd_q <= prev_mem[rd_addr];
      next_rd_q <= next_mem[rd_addr];
      hnd_rd_q  <= hnd_mem[rd_addr];
      ring_rd_q <= ring_mem[pop_q];
      prev_rv_q <= prev_vld_q[rd_addr];
      next_rv_q <= next_vld_q[rd_addr];
      ring_rv_q <= ring_vld_q[pop_q];
      req_q     <= in_word_i;
      exh_q     <= (used_q >= FREE_LIM);
      bad_q     <= in_bad;
      rd_addr_q <= rd_addr;
      slot_q    <= pop_q;
    end
  end

  // ---- result ----
  tpl_pkg::out_word_t res;
  tpl_pkg::out_word_t out_q;

  always_comb begin
    res = '0;
    if (bad_q) begin
      res.status = tpl_pkg::STATUS_OK;
      res.index  = anc;
    end else if (is_ins && exh_q) begin
      res.status = tpl_pkg::STATUS_EXHAUSTED;
    end else if (is_ins) begin
      res.status        = tpl_pkg::STATUS_OK;
      res.index         = new_idx;
      res.entry_handler = tpl_pkg::HND_W'(req_q.handler[HW-1:0]);
      if (req_q.action == tpl_pkg::ACT_INS_AFTER) begin
        res.prev_index = (nxt_fix == new_idx) ? new_idx : anc;
        res.next_index = (anc == new_idx) ? new_idx : nxt;
      end else begin
        res.prev_index = (anc == new_idx) ? new_idx : prv;
        res.next_index = (prv_fix == new_idx) ? new_idx : anc;
      end
    end else begin
      // remove and read both report the anchor's links as they were
      res.status        = tpl_pkg::STATUS_OK;
      res.index         = anc;
      res.prev_index    = prv;
      res.next_index    = nxt;
      res.entry_handler = tpl_pkg::HND_W'(hnd_rd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= res;
  end

  assign out_word_o = out_q;

endmodule

// ===== rtl/task_pool_linked_list.sv =====
// ----------------------------------------------------------------------------
// task_pool_linked_list: task entry pool with free ring and linked list
// Allocates entries from a free-index ring and keeps them on a doubly
// linked list; inserts, removes and reads one request at a time.
// ----------------------------------------------------------------------------
// Usage: one request word in, one result word out, in order. An insert
// passes a read phase, then two write phases (each link table has a
// single write port and an insert rewrites two entries in each). Remove,
// read, an exhausted insert and an out-of-range anchor take the read
// phase and the first write phase only. The input is stalled while a
// request is in progress; a finished result sits in the output register,
// and the next request is taken while it waits, but a second result
// holds the block until the first one leaves. No clearing pass after
// reset: reset values come from per-entry valid bits. Handler values of
// entries never inserted read as garbage; remove indices are not checked.
// ----------------------------------------------------------------------------
module task_pool_linked_list #(
  parameter int POOL_ENTRIES = 72,
  parameter int FREE_SLOTS   = 70,
  parameter int HANDLER_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tpl_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tpl_pkg::out_word_t out_word_o
);

  tpl_pkg::cmd_t    cmd;
  tpl_pkg::status_t sts;

  // sequencer: handshakes and phase control
  tpl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // tables, ring, pointers and the result register
  tpl_dp #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .FREE_SLOTS   (FREE_SLOTS),
    .HANDLER_BITS (HANDLER_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

  // busy right after taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // first write phase follows capture directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr1 |-> $past(cmd.accept))
    else $error("write phase without captured request");

  // second write phase only after the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr2 |-> $past(cmd.wr1))
    else $error("second write phase out of order");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

endmodule

// ===== verif/task_pool_linked_list_test.sv =====
// ----------------------------------------------------------------------------
// task_pool_linked_list_test: self-checking bench for the task entry pool
// Sends insert, remove and read words against a shadow of the pool's links,
// handler table and free ring, and checks every result word in order.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module task_pool_linked_list_test;

  localparam int IDX_W         = tpl_pkg::IDX_W;
  localparam int HND_W         = tpl_pkg::HND_W;
  localparam int ENTRIES       = 72;
  localparam int SLOTS         = 70;
  localparam int RANDOM_WORDS  = 650;
  localparam int MAX_IDLE      = 12;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS   = 10;
  // two copies of the pool state: one walked ahead by the word generator,
  // one advanced only when the block accepts a word
  localparam int SHADOW = 0;
  localparam int LIVE   = 1;

  typedef struct packed {
    logic              hold;  // send only once every result so far has come back
    tpl_pkg::in_word_t word;
  } req_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  tpl_pkg::in_word_t  in_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  tpl_pkg::out_word_t out_word_o;

  // pool state per copy
  logic [IDX_W-1:0] prv_tab     [2][ENTRIES];
  logic [IDX_W-1:0] nxt_tab     [2][ENTRIES];
  logic [HND_W-1:0] hnd_tab     [2][ENTRIES];
  bit               written_tab [2][ENTRIES];  // handler has been stored
  bit               linked_tab  [2][ENTRIES];  // on the list, for stimulus only
  logic [IDX_W-1:0] ring_tab    [2][SLOTS];
  logic [IDX_W-1:0] used_cnt    [2];
  logic [IDX_W-1:0] pop_ptr     [2];
  logic [IDX_W-1:0] push_ptr    [2];

  req_t               pend_q [$];  // words waiting to be sent
  tpl_pkg::out_word_t want_q [$];  // results owed by the block, oldest first
  int unsigned sent_cnt  = 0;
  int unsigned done_cnt  = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned bad_cnt   = 0;
  bit          calm      = 1'b0;  // no idling on either side while set

  task_pool_linked_list #(
    .POOL_ENTRIES (ENTRIES),
    .FREE_SLOTS   (SLOTS),
    .HANDLER_BITS (HND_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #2 clk_i = ~clk_i;

  // Apply one request word to one copy of the pool; returns the result word.
  function automatic tpl_pkg::out_word_t pool_step(int which, tpl_pkg::in_word_t w);
    tpl_pkg::out_word_t r;
    int                 a;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   p;
    logic [IDX_W-1:0]   n;
    r       = '0;
    a       = int'(w.anchor);
    r.index = w.anchor;
    // anchor off the end of the pool: nothing changes, links and handler read 0
    if (a >= ENTRIES) return r;
    case (tpl_pkg::action_e'(w.action))
      tpl_pkg::ACT_INS_AFTER, tpl_pkg::ACT_INS_BEFORE: begin
        if (used_cnt[which] >= SLOTS) begin
          r.status = tpl_pkg::STATUS_EXHAUSTED;
          r.index  = '0;
          return r;
        end
        idx = ring_tab[which][pop_ptr[which]];
        if (idx >= ENTRIES) idx = '0;
        pop_ptr[which] = (pop_ptr[which] == SLOTS - 1) ? '0 : pop_ptr[which] + 1'b1;
        hnd_tab[which][idx]     = w.handler;
        written_tab[which][idx] = 1'b1;
        linked_tab[which][idx]  = 1'b1;
        if (w.action == tpl_pkg::ACT_INS_BEFORE) begin
          prv_tab[which][idx] = prv_tab[which][a];
          nxt_tab[which][idx] = w.anchor;
          p = prv_tab[which][a];
          if (p >= ENTRIES) p = '0;
          nxt_tab[which][p] = idx;
          prv_tab[which][a] = idx;
        end else begin
          prv_tab[which][idx] = w.anchor;
          nxt_tab[which][idx] = nxt_tab[which][a];
          n = nxt_tab[which][a];
          if (n >= ENTRIES) n = '0;
          prv_tab[which][n] = idx;
          nxt_tab[which][a] = idx;
        end
        used_cnt[which] = used_cnt[which] + 1'b1;
        r.index = idx;
      end
      tpl_pkg::ACT_REMOVE: begin
        // unchecked: neighbours get rewritten even if the entry is not linked
        p = prv_tab[which][a];
        if (p >= ENTRIES) p = '0;
        nxt_tab[which][p] = nxt_tab[which][a];
        n = nxt_tab[which][a];
        if (n >= ENTRIES) n = '0;
        prv_tab[which][n] = prv_tab[which][a];
        ring_tab[which][push_ptr[which]] = w.anchor;
        push_ptr[which] = (push_ptr[which] == SLOTS - 1) ? '0 : push_ptr[which] + 1'b1;
        used_cnt[which] = used_cnt[which] - 1'b1;  // wraps below zero
        linked_tab[which][a] = 1'b0;
      end
      default: ;
    endcase
    // report the entry as it stands after the operation
    r.prev_index    = prv_tab[which][r.index];
    r.next_index    = nxt_tab[which][r.index];
    r.entry_handler = hnd_tab[which][r.index];
    return r;
  endfunction

  // Random entry of the shadow pool that is linked, or merely written; -1 if none.
  function automatic int pick_entry(bit want_linked);
    int hits [$];
    for (int e = 0; e < ENTRIES; e++)
      if (want_linked ? linked_tab[SHADOW][e] : written_tab[SHADOW][e]) hits.push_back(e);
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic int unsigned idle_draw();
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  task automatic queue_word(tpl_pkg::action_e act, int anchor, logic [HND_W-1:0] hnd,
                            bit hold);
    req_t r;
    r.hold         = hold;
    r.word.action  = act;
    r.word.anchor  = IDX_W'(anchor);
    r.word.handler = hnd;
    void'(pool_step(SHADOW, r.word));
    pend_q.push_back(r);
  endtask

  // Stretches without idling come and go at random.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
  end

  // Sender: holds a word until taken, then idles a drawn number of cycles.
  // Expected results are computed at the edge where the word is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap;
    bit          took;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      send_wait  <= 0;
      sent_cnt   <= 0;
    end else begin
      took = in_valid_i && !in_stall_o;
      gap  = send_wait;
      if (took) begin
        want_q.push_back(pool_step(LIVE, in_word_i));
        sent_cnt <= sent_cnt + 1;
        gap = idle_draw();
      end
      if (!in_valid_i || took) begin
        // a held word waits until the counts agree; the counters are
        // registered, so a word taken at this edge also blocks it
        if (gap == 0 && pend_q.size() != 0 &&
            (!pend_q[0].hold || (!took && sent_cnt == done_cnt))) begin
          in_word_i  <= pend_q[0].word;
          in_valid_i <= 1'b1;
          void'(pend_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
          send_wait  <= (gap == 0) ? 0 : gap - 1;
        end
      end
    end
  end

  // Receiver: checks each taken result against the oldest expectation and
  // stalls for a drawn number of cycles after it.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned        stall_n;
    tpl_pkg::out_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait   <= 0;
      done_cnt    <= 0;
    end else begin
      stall_n = recv_wait;
      if (out_valid_o && !out_stall_i) begin
        done_cnt <= done_cnt + 1;
        stall_n = idle_draw();
        if (want_q.size() == 0) begin
          if (bad_cnt < MAX_REPORTS)
            $display("unexpected result word: st=%0d idx=%0d prv=%0d nxt=%0d hnd=%h",
                     out_word_o.status, out_word_o.index, out_word_o.prev_index,
                     out_word_o.next_index, out_word_o.entry_handler);
          bad_cnt++;
        end else begin
          want = want_q.pop_front();
          if (out_word_o.status !== want.status || out_word_o.index !== want.index ||
              out_word_o.prev_index !== want.prev_index ||
              out_word_o.next_index !== want.next_index ||
              out_word_o.entry_handler !== want.entry_handler) begin
            if (bad_cnt < MAX_REPORTS) begin
              $write("result mismatch: want st=%0d idx=%0d prv=%0d nxt=%0d hnd=%h, ",
                     want.status, want.index, want.prev_index, want.next_index,
                     want.entry_handler);
              $display("got st=%0d idx=%0d prv=%0d nxt=%0d hnd=%h", out_word_o.status,
                       out_word_o.index, out_word_o.prev_index, out_word_o.next_index,
                       out_word_o.entry_handler);
            end
            bad_cnt++;
          end
        end
      end
      out_stall_i <= (stall_n != 0);
      recv_wait   <= (stall_n == 0) ? 0 : stall_n - 1;
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int               live;
    int               old;
    int               roll;
    int               anchor;
    bit               filling;
    bit               want_ins;
    bit               want_rm;
    logic [HND_W-1:0] h;

    // pool after reset, both copies
    for (int c = 0; c < 2; c++) begin
      for (int e = 0; e < ENTRIES; e++) begin
        prv_tab[c][e]     = '0;
        nxt_tab[c][e]     = '0;
        hnd_tab[c][e]     = '0;
        written_tab[c][e] = 1'b0;
        linked_tab[c][e]  = 1'b0;
      end
      nxt_tab[c][0] = IDX_W'(1);
      for (int s = 0; s < SLOTS; s++) ring_tab[c][s] = IDX_W'(s + 2);
      used_cnt[c] = '0;
      pop_ptr[c]  = '0;
      push_ptr[c] = '0;
    end

    // Directed: fresh entries come off the ring as 2, 3, 4, 5.
    queue_word(tpl_pkg::ACT_INS_AFTER, 0, 16'hFFFF, 1'b0);
    queue_word(tpl_pkg::ACT_INS_BEFORE, 1, 16'h0000, 1'b0);
    queue_word(tpl_pkg::ACT_INS_AFTER, ENTRIES - 1, 16'h8001, 1'b0);  // top anchor
    queue_word(tpl_pkg::ACT_INS_BEFORE, 2, 16'h7FFE, 1'b0);
    queue_word(tpl_pkg::ACT_READ, 2, 16'h5555, 1'b1);                  // drain first
    queue_word(tpl_pkg::ACT_READ, 5, 16'hAAAA, 1'b0);
    // anchors past the pool on every action
    queue_word(tpl_pkg::ACT_READ, 127, 16'hFFFF, 1'b0);
    queue_word(tpl_pkg::ACT_INS_AFTER, ENTRIES, 16'hFFFF, 1'b0);
    queue_word(tpl_pkg::ACT_INS_BEFORE, 100, 16'h1234, 1'b0);
    queue_word(tpl_pkg::ACT_REMOVE, 90, 16'h0F0F, 1'b0);
    // remove a linked entry, then again while unlinked
    queue_word(tpl_pkg::ACT_REMOVE, 3, 16'h0000, 1'b0);
    queue_word(tpl_pkg::ACT_REMOVE, 3, 16'h0000, 1'b0);
    queue_word(tpl_pkg::ACT_READ, 3, 16'h0000, 1'b0);
    queue_word(tpl_pkg::ACT_REMOVE, 5, 16'hFFFF, 1'b0);
    queue_word(tpl_pkg::ACT_READ, 2, 16'hFFFF, 1'b0);

    // Random: alternating fill and drain bursts so the pool runs dry and
    // recovers; a little noise on top. Removes and reads only ever touch
    // entries whose handler has been stored.
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      filling  = ((k / 100) % 2 == 0);
      roll     = $urandom_range(0, 99);
      live     = pick_entry(1'b1);
      old      = pick_entry(1'b0);
      h        = HND_W'($urandom);
      want_ins = filling ? (roll < 85) : (roll < 40);
      want_rm  = filling ? (roll < 93) : (roll < 85);
      if (roll < 3) begin
        queue_word(tpl_pkg::action_e'($urandom_range(0, 3)),
                   $urandom_range(ENTRIES, 127), h, k % 150 == 0);
      end else if (roll < 6 && old >= 0 && used_cnt[SHADOW] != 0) begin
        queue_word(tpl_pkg::ACT_REMOVE, old, h, k % 150 == 0);   // may be unlinked
      end else if (roll < 10 && old >= 0) begin
        queue_word(tpl_pkg::ACT_READ, old, h, k % 150 == 0);
      end else if (roll < 13) begin
        queue_word(tpl_pkg::action_e'($urandom_range(0, 1)),
                   $urandom_range(0, ENTRIES - 1), h, k % 150 == 0);
      end else if (want_ins || live < 0 || used_cnt[SHADOW] == 0) begin
        anchor = (live < 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : live;
        queue_word(tpl_pkg::action_e'($urandom_range(0, 1)), anchor, h, k % 150 == 0);
      end else if (want_rm) begin
        queue_word(tpl_pkg::ACT_REMOVE, live, h, k % 150 == 0);
      end else begin
        queue_word(tpl_pkg::ACT_READ, live, h, k % 150 == 0);
      end
    end

    // Close out: empty the count, then remove once more so it wraps and
    // an insert reads as exhausted.
    while (used_cnt[SHADOW] != 0)
      queue_word(tpl_pkg::ACT_REMOVE, pick_entry(1'b0), HND_W'($urandom), 1'b0);
    old = pick_entry(1'b0);
    queue_word(tpl_pkg::ACT_REMOVE, old, 16'h0000, 1'b1);
    queue_word(tpl_pkg::ACT_INS_BEFORE, 0, 16'hFFFF, 1'b0);
    queue_word(tpl_pkg::ACT_READ, old, 16'h0000, 1'b0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (pend_q.size() != 0 || in_valid_i || sent_cnt > done_cnt);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (bad_cnt == 0 && want_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
